[src/ltda_pkg.sv]
// ----------------------------------------------------------------------------
// ltda_pkg
// Shared constants, types and the decay table for the load tracking block.
// ----------------------------------------------------------------------------
`default_nettype none
package ltda_pkg;

   localparam int unsigned LoadSumMax    = 47742;
   localparam int unsigned CapacityShift = 10;

   localparam logic [19:0] LoadAvgMax     = 20'hFFFFF;
   localparam logic [25:0] RunnableAvgMax = 26'h3FFFFFF;
   localparam logic [10:0] UtilAvgMax     = 11'h7FF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEC_LOAD,
      ST_DEC_RUN,
      ST_DEC_UTIL,
      ST_DEC_C1,
      ST_DEC_MAX,
      ST_ADD,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_UTIL,
      ST_DONE
   } state_type;

   function automatic logic [31:0] y_pow(input logic [4:0] idx);
      logic [31:0] r;
      begin
         unique case (idx)
            5'd0:  r = 32'hffffffff;  5'd1:  r = 32'hfa83b2da;
            5'd2:  r = 32'hf5257d14;  5'd3:  r = 32'hefe4b99a;
            5'd4:  r = 32'heac0c6e6;  5'd5:  r = 32'he5b906e6;
            5'd6:  r = 32'he0ccdeeb;  5'd7:  r = 32'hdbfbb796;
            5'd8:  r = 32'hd744fcc9;  5'd9:  r = 32'hd2a81d91;
            5'd10: r = 32'hce248c14;  5'd11: r = 32'hc9b9bd85;
            5'd12: r = 32'hc5672a10;  5'd13: r = 32'hc12c4cc9;
            5'd14: r = 32'hbd08a39e;  5'd15: r = 32'hb8fbaf46;
            5'd16: r = 32'hb504f333;  5'd17: r = 32'hb123f581;
            5'd18: r = 32'had583ee9;  5'd19: r = 32'ha9a15ab4;
            5'd20: r = 32'ha5fed6a9;  5'd21: r = 32'ha2704302;
            5'd22: r = 32'h9ef5325f;  5'd23: r = 32'h9b8d39b9;
            5'd24: r = 32'h9837f050;  5'd25: r = 32'h94f3efe0;
            5'd26: r = 32'h91c3d373;  5'd27: r = 32'h8ea4398a;
            5'd28: r = 32'h8b95c1e3;  5'd29: r = 32'h88980e80;
            5'd30: r = 32'h85aac367;  default: r = 32'h82cd8698;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

[src/load_tracking_decay_avg.sv]
// ----------------------------------------------------------------------------
// load_tracking_decay_avg
// Decayed load / runnable / utilization tracking with periodic averages.
// ----------------------------------------------------------------------------
// Sequence (accept to result transfer): with no update the result is posted;
//   an update without a boundary runs three accumulate steps; across a boundary:
//   5 two-pass decays (3 at zero weight), accumulate, 3 68-step divides + setup.
// Throughput: one item at a time; req_stall is high from acceptance until the
//   result transfer completes.
// Reset: synchronous, clears all sums, averages and the timestamp.
`default_nettype none
module load_tracking_decay_avg (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_now_ns,
   input  wire logic [19:0] req_activity_weight,
   input  wire logic [15:0] req_runnable_count,
   input  wire logic        req_running_flag,
   input  wire logic [19:0] req_avg_weight,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_period_crossed,
   output logic [19:0]      rsp_load_average,
   output logic [25:0]      rsp_runnable_average,
   output logic [10:0]      rsp_util_average
);
   import ltda_pkg::*;

   state_type state_ff, state_in;

   // architectural state
   logic [63:0] last_time_ff, last_time_in;
   logic [47:0] load_acc_ff, load_acc_in;
   logic [47:0] run_acc_ff, run_acc_in;
   logic [31:0] util_acc_ff, util_acc_in;
   logic [9:0]  frac_ff, frac_in;
   logic [19:0] load_mean_ff, load_mean_in;
   logic [25:0] run_avg_ff, run_avg_in;
   logic [10:0] util_mean_ff, util_mean_in;

   // per-item working registers
   logic [19:0] load_ff, load_in;
   logic [15:0] runc_ff, runc_in;
   logic        running_ff, running_in;
   logic [19:0] aw_ff, aw_in;
   logic [53:0] periods_ff, periods_in;   // delta + fraction, >> 10
   logic [9:0]  rem_ff, rem_in;
   logic [31:0] contrib_ff, contrib_in;
   logic        crossed_ff, crossed_in;
   logic [31:0] c1_ff, c1_in;
   logic        half_ff, half_in;        // decay: first or second partial product
   logic [63:0] part_ff, part_in;        // low partial product >> 32
   logic [1:0]  add_ff, add_in;          // accumulate sub-step
   logic        pend_ff, pend_in;        // result waiting

   // divider: 68-bit dividend, 17-bit divisor, one quotient bit per cycle
   logic [67:0] dq_ff, dq_in;
   logic [16:0] drem_ff, drem_in;
   logic [6:0]  dcnt_ff, dcnt_in;
   logic        dbusy_ff, dbusy_in;

   // shared multiplier, 32x32
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   assign mul_p = mul_a * mul_b;

   // decay operand select
   logic [47:0] dec_val;
   logic [47:0] dec_shifted;
   logic        dec_zero;
   always_comb begin
      unique case (state_ff)
         ST_DEC_LOAD: dec_val = load_acc_ff;
         ST_DEC_RUN:  dec_val = run_acc_ff;
         ST_DEC_UTIL: dec_val = {16'd0, util_acc_ff};
         ST_DEC_C1:   dec_val = 48'd1024 - {38'd0, frac_ff};
         default:     dec_val = 48'(LoadSumMax);
      endcase
      dec_zero    = periods_ff > 54'd2016;
      dec_shifted = (periods_ff[10:5] >= 6'd48) ? 48'd0 : dec_val >> periods_ff[10:5];
   end

   logic [16:0] divisor;
   assign divisor = 17'(LoadSumMax - 1024) + {7'd0, frac_ff};

   logic [17:0] dtrial;
   assign dtrial = {drem_ff, dq_ff[67]} - {1'b0, divisor};

   logic [63:0] delta;
   logic [53:0] dunits;
   logic [63:0] dsum;
   assign delta  = req_now_ns - last_time_ff;
   assign dunits = delta[63:10];
   assign dsum   = {10'd0, dunits} + {54'd0, frac_ff};

   logic accept;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || pend_ff;
   assign rsp_valid = pend_ff;
   assign rsp_load_average     = load_mean_ff;
   assign rsp_runnable_average = run_avg_ff;
   assign rsp_util_average     = util_mean_ff;
   assign rsp_period_crossed   = crossed_ff;

   logic [63:0] dec_res;
   logic [63:0] prod_wide;
   always_comb begin
      state_in = state_ff;
      last_time_in = last_time_ff; load_acc_in = load_acc_ff; run_acc_in = run_acc_ff;
      util_acc_in = util_acc_ff; frac_in = frac_ff; load_mean_in = load_mean_ff;
      run_avg_in = run_avg_ff; util_mean_in = util_mean_ff;
      load_in = load_ff; runc_in = runc_ff; running_in = running_ff; aw_in = aw_ff;
      periods_in = periods_ff; rem_in = rem_ff; contrib_in = contrib_ff;
      crossed_in = crossed_ff; c1_in = c1_ff; half_in = half_ff; part_in = part_ff;
      add_in = add_ff; pend_in = pend_ff;
      dq_in = dq_ff; drem_in = drem_ff; dcnt_in = dcnt_ff; dbusy_in = dbusy_ff;
      mul_a = 32'd0; mul_b = 32'd0;
      dec_res = 64'd0; prod_wide = 64'd0;

      if (pend_ff && !rsp_stall) pend_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               crossed_in = 1'b0;
               if (delta[63]) begin
                  last_time_in = req_now_ns;
                  pend_in = 1'b1;
               end else if (dunits == 54'd0) begin
                  pend_in = 1'b1;
               end else begin
                  last_time_in = last_time_ff + {dunits, 10'd0};
                  load_in    = req_activity_weight;
                  runc_in    = (req_activity_weight == 20'd0) ? 16'd0 : req_runnable_count;
                  running_in = (req_activity_weight == 20'd0) ? 1'b0 : req_running_flag;
                  aw_in      = req_avg_weight;
                  contrib_in = dunits[31:0];
                  periods_in = dsum[63:10];
                  rem_in     = dsum[9:0];
                  half_in    = 1'b0;
                  add_in     = 2'd0;
                  if (dsum[63:10] != 54'd0) begin
                     crossed_in = 1'b1;
                     state_in   = ST_DEC_LOAD;
                  end else begin
                     frac_in  = dsum[9:0];
                     state_in = ST_ADD;
                  end
               end
            end
         end
         ST_DEC_LOAD, ST_DEC_RUN, ST_DEC_UTIL, ST_DEC_C1, ST_DEC_MAX: begin
            // two passes: low word product, then high word product plus carry-in
            mul_b = y_pow(periods_ff[4:0]);
            if (!half_ff) begin
               mul_a   = dec_shifted[31:0];
               part_in = {32'd0, mul_p[63:32]};
               half_in = 1'b1;
            end else begin
               mul_a   = {16'd0, dec_shifted[47:32]};
               dec_res = dec_zero ? 64'd0 : (mul_p + part_ff);
               half_in = 1'b0;
               unique case (state_ff)
                  ST_DEC_LOAD: begin load_acc_in = dec_res[47:0]; state_in = ST_DEC_RUN; end
                  ST_DEC_RUN:  begin run_acc_in = dec_res[47:0]; state_in = ST_DEC_UTIL; end
                  ST_DEC_UTIL: begin
                     util_acc_in = dec_res[31:0];
                     state_in = (load_ff != 20'd0) ? ST_DEC_C1 : ST_ADD;
                     if (load_ff == 20'd0) frac_in = rem_ff;
                  end
                  ST_DEC_C1: begin c1_in = dec_res[31:0]; state_in = ST_DEC_MAX; end
                  default: begin
                     contrib_in = c1_ff + 32'(LoadSumMax) - dec_res[31:0] - 32'd1024
                                  + {22'd0, rem_ff};
                     frac_in  = rem_ff;
                     state_in = ST_ADD;
                  end
               endcase
            end
         end
         ST_ADD: begin
            unique case (add_ff)
               2'd0: begin
                  mul_a = {12'd0, load_ff}; mul_b = contrib_ff;
                  if (load_ff != 20'd0) load_acc_in = load_acc_ff + mul_p[47:0];
                  add_in = 2'd1;
               end
               2'd1: begin
                  mul_a = {16'd0, runc_ff}; mul_b = contrib_ff;
                  prod_wide = mul_p << CapacityShift;
                  if (load_ff != 20'd0 && runc_ff != 16'd0)
                     run_acc_in = run_acc_ff + prod_wide[47:0];
                  add_in = 2'd2;
               end
               default: begin
                  if (load_ff != 20'd0 && running_ff)
                     util_acc_in = util_acc_ff + (contrib_ff << CapacityShift);
                  add_in = 2'd0;
                  if (crossed_ff) begin
                     state_in = ST_DIV_LOAD;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            endcase
         end
         ST_DIV_LOAD, ST_DIV_RUN, ST_DIV_UTIL: begin
            if (!dbusy_ff) begin
               // load dividend; load needs aw * load_acc (48x20 as two products)
               unique case (state_ff)
                  ST_DIV_LOAD: begin
                     if (dcnt_ff == 7'd0) begin
                        mul_a = {12'd0, aw_ff}; mul_b = load_acc_ff[31:0];
                        part_in = mul_p;
                        dcnt_in = 7'd1;
                     end else begin
                        // weighted load sum wraps at 64 bits
                        mul_a = {12'd0, aw_ff}; mul_b = {16'd0, load_acc_ff[47:32]};
                        dq_in = {4'd0, {mul_p[31:0], 32'd0} + part_ff};
                        drem_in = 17'd0; dcnt_in = 7'd68; dbusy_in = 1'b1;
                     end
                  end
                  ST_DIV_RUN: begin
                     dq_in = {20'd0, run_acc_ff}; drem_in = 17'd0;
                     dcnt_in = 7'd68; dbusy_in = 1'b1;
                  end
                  default: begin
                     dq_in = {36'd0, util_acc_ff}; drem_in = 17'd0;
                     dcnt_in = 7'd68; dbusy_in = 1'b1;
                  end
               endcase
            end else if (dcnt_ff != 7'd0) begin
               if (!dtrial[17]) begin
                  drem_in = dtrial[16:0];
                  dq_in   = {dq_ff[66:0], 1'b1};
               end else begin
                  drem_in = {drem_ff[15:0], dq_ff[67]};
                  dq_in   = {dq_ff[66:0], 1'b0};
               end
               dcnt_in = dcnt_ff - 7'd1;
            end else begin
               dbusy_in = 1'b0;
               unique case (state_ff)
                  ST_DIV_LOAD: begin
                     load_mean_in = (dq_ff > {48'd0, LoadAvgMax}) ? LoadAvgMax : dq_ff[19:0];
                     state_in = ST_DIV_RUN;
                  end
                  ST_DIV_RUN: begin
                     run_avg_in = (dq_ff > {42'd0, RunnableAvgMax}) ?
                                  RunnableAvgMax : dq_ff[25:0];
                     state_in = ST_DIV_UTIL;
                  end
                  default: begin
                     util_mean_in = (dq_ff > {57'd0, UtilAvgMax}) ? UtilAvgMax : dq_ff[10:0];
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            pend_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_time_ff <= '0; load_acc_ff <= '0; run_acc_ff <= '0; util_acc_ff <= '0;
         frac_ff <= '0; load_mean_ff <= '0; run_avg_ff <= '0; util_mean_ff <= '0;
         pend_ff <= 1'b0; dbusy_ff <= 1'b0; dcnt_ff <= '0; half_ff <= 1'b0;
         add_ff <= '0; crossed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_time_ff <= last_time_in; load_acc_ff <= load_acc_in;
         run_acc_ff <= run_acc_in; util_acc_ff <= util_acc_in; frac_ff <= frac_in;
         load_mean_ff <= load_mean_in; run_avg_ff <= run_avg_in;
         util_mean_ff <= util_mean_in;
         pend_ff <= pend_in; dbusy_ff <= dbusy_in; dcnt_ff <= dcnt_in;
         half_ff <= half_in; add_ff <= add_in; crossed_ff <= crossed_in;
      end
   end

   always_ff @(posedge clock) begin
      load_ff <= load_in; runc_ff <= runc_in; running_ff <= running_in; aw_ff <= aw_in;
      periods_ff <= periods_in; rem_ff <= rem_in; contrib_ff <= contrib_in;
      c1_ff <= c1_in; part_ff <= part_in; dq_ff <= dq_in; drem_ff <= drem_in;
   end

endmodule
`default_nettype wire

[verif/tb_load_tracking_decay_avg.sv]
// ----------------------------------------------------------------------------
// tb_load_tracking_decay_avg
// Self-checking bench for the decayed load tracker: directed table, then
// random update streams with random idle and stall on both channels; every
// result transfer is compared against an in-bench model of the decay math.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_load_tracking_decay_avg;
   timeunit 1ns;
   timeprecision 1ps;
   import ltda_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_now_ns;
   logic [19:0] req_activity_weight;
   logic [15:0] req_runnable_count;
   logic        req_running_flag;
   logic [19:0] req_avg_weight;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_period_crossed;
   logic [19:0] rsp_load_average;
   logic [25:0] rsp_runnable_average;
   logic [10:0] rsp_util_average;

   load_tracking_decay_avg DUT (.*);

   typedef struct packed {
      logic [63:0] now_ns;
      logic [19:0] weight;
      logic [15:0] runnable;
      logic        running;
      logic [19:0] avg_w;
   } sample_type;

   typedef struct packed {
      logic        crossed;
      logic [19:0] load_mean;
      logic [25:0] run_avg;
      logic [10:0] util_mean;
   } avg_type;

   // directed row: stimulus plus an optional typed-in expectation
   typedef struct {
      sample_type s;
      bit         fixed;
      avg_type    want;
   } row_type;

   // y^n in Q32, n = 0..31 (y^32 = 1/2)
   localparam logic [31:0] YTAB [32] = '{
      32'hffffffff, 32'hfa83b2da, 32'hf5257d14, 32'hefe4b99a, 32'heac0c6e6,
      32'he5b906e6, 32'he0ccdeeb, 32'hdbfbb796, 32'hd744fcc9, 32'hd2a81d91,
      32'hce248c14, 32'hc9b9bd85, 32'hc5672a10, 32'hc12c4cc9, 32'hbd08a39e,
      32'hb8fbaf46, 32'hb504f333, 32'hb123f581, 32'had583ee9, 32'ha9a15ab4,
      32'ha5fed6a9, 32'ha2704302, 32'h9ef5325f, 32'h9b8d39b9, 32'h9837f050,
      32'h94f3efe0, 32'h91c3d373, 32'h8ea4398a, 32'h8b95c1e3, 32'h88980e80,
      32'h85aac367, 32'h82cd8698};

   // tracker model state
   logic [63:0] m_last;
   logic [47:0] m_load_sum, m_run_sum;
   logic [31:0] m_util_sum;
   logic [9:0]  m_frac;
   logic [19:0] m_load_mean;
   logic [25:0] m_run_avg;
   logic [10:0] m_util_mean;

   avg_type     pending_avgs[$];
   int          errors = 0;
   bit          idle_free = 0;   // long stretch with no idling on either side
   int          accepted = 0;

   function automatic logic [63:0] decay_by(logic [63:0] v, logic [63:0] n);
      logic [63:0] m;
      if (n > 64'd2016) return 64'd0;
      v = v >> n[10:5];
      m = {32'd0, YTAB[n[4:0]]};
      return (v >> 32) * m + (((v & 64'hFFFFFFFF) * m) >> 32);
   endfunction

   function automatic logic [63:0] clip(logic [63:0] v, logic [63:0] mx);
      return (v > mx) ? mx : v;
   endfunction

   function automatic avg_type track_update(sample_type s);
      logic [63:0] delta, periods, contrib, rem, c1, c2, dv, ld, rn, rf, prod;
      bit crossed;
      avg_type r;
      crossed = 0;
      ld = {44'd0, s.weight}; rn = {48'd0, s.runnable}; rf = {63'd0, s.running};
      delta = s.now_ns - m_last;
      if (delta[63]) begin
         m_last = s.now_ns;
      end else begin
         delta = delta >> 10;
         if (delta != 0) begin
            m_last = m_last + (delta << 10);
            if (ld == 0) begin
               rn = 0;
               rf = 0;
            end
            contrib = delta & 64'hFFFFFFFF;
            delta = delta + {54'd0, m_frac};
            periods = delta >> 10;
            if (periods != 0) begin
               rem = delta & 64'd1023;
               m_load_sum = 48'(decay_by({16'd0, m_load_sum}, periods));
               m_run_sum  = 48'(decay_by({16'd0, m_run_sum}, periods));
               m_util_sum = 32'(decay_by({32'd0, m_util_sum}, periods));
               if (ld != 0) begin
                  c1 = decay_by(64'd1024 - {54'd0, m_frac}, periods);
                  c2 = 64'(LoadSumMax) - decay_by(64'(LoadSumMax), periods) - 64'd1024;
                  contrib = (c1 + c2 + rem) & 64'hFFFFFFFF;
               end
               m_frac = rem[9:0];
               crossed = 1;
            end else begin
               m_frac = delta[9:0];
            end
            if (ld != 0) begin
               m_load_sum = 48'({16'd0, m_load_sum} + ld * contrib);
               if (rn != 0)
                  m_run_sum = 48'({16'd0, m_run_sum} + ((rn * contrib) << CapacityShift));
               if (rf != 0)
                  m_util_sum = 32'({32'd0, m_util_sum} + (contrib << CapacityShift));
            end
            if (crossed) begin
               dv = 64'(LoadSumMax) - 64'd1024 + {54'd0, m_frac};
               // weighted load sum wraps at 64 bits
               prod = {44'd0, s.avg_w} * {16'd0, m_load_sum};
               m_load_mean = 20'(clip(prod / dv, {44'd0, LoadAvgMax}));
               m_run_avg   = 26'(clip({16'd0, m_run_sum} / dv, {38'd0, RunnableAvgMax}));
               m_util_mean = 11'(clip({32'd0, m_util_sum} / dv, {53'd0, UtilAvgMax}));
            end
         end
      end
      r.crossed = crossed;
      r.load_mean = m_load_mean;
      r.run_avg = m_run_avg;
      r.util_mean = m_util_mean;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
      errors++;
   endtask

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // result side: random stall, compare each transfer with oldest expectation
   always @(posedge clock) begin
      avg_type w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_avgs.size() == 0) begin
               report_mismatch("unexpected transfer", 1, 0);
            end else begin
               w = pending_avgs.pop_front();
               if (rsp_period_crossed !== w.crossed)
                  report_mismatch("period_crossed", rsp_period_crossed, w.crossed);
               if (rsp_load_average !== w.load_mean)
                  report_mismatch("load_average", rsp_load_average, w.load_mean);
               if (rsp_runnable_average !== w.run_avg)
                  report_mismatch("runnable_average", rsp_runnable_average, w.run_avg);
               if (rsp_util_average !== w.util_mean)
                  report_mismatch("util_average", rsp_util_average, w.util_mean);
            end
         end
         rsp_stall <= !idle_free && ($urandom_range(99) < 16);
      end
   end

   // one transfer on the request side; random idle before it
   task automatic send(sample_type s);
      while (!idle_free && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_now_ns          <= s.now_ns;
      req_activity_weight <= s.weight;
      req_runnable_count  <= s.runnable;
      req_running_flag    <= s.running;
      req_avg_weight      <= s.avg_w;
      do @(posedge clock); while (req_stall);
      pending_avgs.push_back(track_update(s));
      accepted++;
   endtask

   function automatic sample_type mk(logic [63:0] t, logic [19:0] w, logic [15:0] r,
                                     logic f, logic [19:0] a);
      sample_type s;
      s.now_ns = t; s.weight = w; s.runnable = r; s.running = f; s.avg_w = a;
      return s;
   endfunction

   row_type     directed[$];
   logic [63:0] clk_ns;

   initial begin
      row_type    rw;
      sample_type s;
      avg_type    zero_avg;
      int         n;
      zero_avg = '0;
      reset = 1'b1;
      req_valid = 0; req_now_ns = 0; req_activity_weight = 0;
      req_runnable_count = 0; req_running_flag = 0; req_avg_weight = 0;
      m_last = 0; m_load_sum = 0; m_run_sum = 0; m_util_sum = 0; m_frac = 0;
      m_load_mean = 0; m_run_avg = 0; m_util_mean = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; fixed rows are those readable at a glance
      // under one unit elapsed: nothing changes
      rw.s = mk(64'd1023, 20'hFFFFF, 16'hFFFF, 1, 20'hFFFFF);
      rw.fixed = 1; rw.want = zero_avg; directed.push_back(rw);
      // time going back from zero: resync, no update
      rw.s = mk(64'hFFFF_FFFF_FFFF_FFFF, 20'hFFFFF, 16'hFFFF, 1, 20'hFFFFF);
      directed.push_back(rw);
      // back to zero: wraps forward by one ns, under one unit
      rw.s = mk(64'd0, 20'd1, 16'd1, 1, 20'd1); rw.fixed = 0; directed.push_back(rw);
      rw.fixed = 0;
      rw.s = mk(64'd1024, 20'hFFFFF, 16'hFFFF, 1, 20'hFFFFF); directed.push_back(rw);
      rw.s = mk(64'd600_000, 20'hFFFFF, 16'hFFFF, 1, 20'hFFFFF); directed.push_back(rw);
      rw.s = mk(64'd1_700_000, 20'd1024, 16'd1, 0, 20'd1024); directed.push_back(rw);
      // zero weight: decay only
      rw.s = mk(64'd3_000_000, 20'd0, 16'hFFFF, 1, 20'hFFFFF); directed.push_back(rw);
      rw.s = mk(64'd3_100_000, 20'd1, 16'd0, 1, 20'd0); directed.push_back(rw);
      // time went back
      rw.s = mk(64'd2_000_000, 20'd500, 16'd2, 1, 20'd77); directed.push_back(rw);
      rw.s = mk(64'd2_400_000, 20'h80000, 16'h8000, 1, 20'h80000); directed.push_back(rw);
      // exactly at and far past the zeroing limit of 2016 periods
      rw.s = mk(64'd2_400_000 + 64'd2016 * 1024 * 1024, 20'd1000, 16'd3, 1, 20'd9);
      directed.push_back(rw);
      rw.s = mk(64'h0000_0100_0000_0000, 20'hFFFFF, 16'hFFFF, 1, 20'hFFFFF);
      directed.push_back(rw);
      // jump to the largest positive timestamp
      rw.s = mk(64'h7FFF_FFFF_FFFF_FFFF, 20'h55555, 16'hAAAA, 0, 20'hAAAAA);
      directed.push_back(rw);
      rw.s = mk(64'h7FFF_FFFF_FFFF_FFFF + 64'd5_000_000, 20'hAAAAA, 16'h5555, 1, 20'h55555);
      directed.push_back(rw);
      rw.s = mk(64'hFFFF_FFFF_FFF0_0000, 20'hFFFFF, 16'hFFFF, 1, 20'hFFFFF);
      directed.push_back(rw);

      foreach (directed[i]) begin
         send(directed[i].s);
         if (directed[i].fixed && pending_avgs[$] !== directed[i].want)
            report_mismatch("directed row", i, 0);
      end
      req_valid <= 1'b0;

      // pause the sender until every expected transfer has arrived
      while (pending_avgs.size() != 0) @(posedge clock);

      // random streams: mostly forward steps of realistic size, some noise
      clk_ns = m_last;
      n = 0;
      while (n < 600) begin
         idle_free = (n >= 250 && n < 330);
         case ($urandom_range(19))
            0:       clk_ns = clk_ns - $urandom_range(5_000_000);        // back
            1:       clk_ns = clk_ns + $urandom_range(1023);             // sub-unit
            2:       clk_ns = clk_ns + ({$urandom, $urandom} >> $urandom_range(63));
            3:       clk_ns = {$urandom, $urandom};
            4, 5, 6: clk_ns = clk_ns + $urandom_range(2_000_000);        // < 2 periods
            default: clk_ns = clk_ns + $urandom_range(60_000_000);
         endcase
         s.now_ns   = clk_ns;
         s.weight   = ($urandom_range(9) == 0) ? 20'd0 :
                      ($urandom_range(4) == 0) ? 20'($urandom) : 20'($urandom_range(1024));
         s.runnable = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(4));
         s.running  = 1'($urandom);
         s.avg_w    = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(2048));
         send(s);
         n++;
      end
      req_valid <= 1'b0;
      idle_free = 0;

      while (pending_avgs.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // ~620 items x (full update sequence + stalls) x 12 ns clock, taken several times over
   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire
